// ----- design/dhi_pkg.sv -----
package dhi_pkg;
    localparam int CFG_TABLE_SIZE = 0;
    localparam int CFG_SECOND_MOD = 1;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        T_FR_IDLE,
        T_FR_DIV,
        T_FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        T_BK_IDLE,
        T_BK_READ,
        T_BK_CHECK,
        T_BK_OUT
    } t_back_state;
endpackage

// ----- design/dhi_front.sv -----
module dhi_front import dhi_pkg::*; #(
    parameter int KEY_WIDTH = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [6:0]           i_size,
    input  logic [15:0]          i_modr,
    output logic                 o_push,
    input  logic                 i_full,
    output logic [6:0]           o_home,
    output logic [16:0]          o_step
);
    localparam int CW = $clog2(KEY_WIDTH + 1);

    t_front_state r_state, n_state;
    logic [KEY_WIDTH-1:0] r_q1, r_q2;
    logic [6:0]           r_rem1;
    logic [16:0]          r_rem2;
    logic [CW-1:0]        r_cnt;
    logic [7:0]           w_t1;
    logic [17:0]          w_t2;

    assign w_t1 = {r_rem1, r_q1[KEY_WIDTH-1]};
    assign w_t2 = {r_rem2, r_q2[KEY_WIDTH-1]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_FR_IDLE: if (i_valid) n_state = T_FR_DIV;
            T_FR_DIV:  if (r_cnt == CW'(KEY_WIDTH - 1)) n_state = T_FR_PUSH;
            T_FR_PUSH: if (!i_full) n_state = T_FR_IDLE;
            default:   n_state = T_FR_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != T_FR_IDLE);
        o_push  = (r_state == T_FR_PUSH) && !i_full;
        o_home  = r_rem1;
        o_step  = {1'b0, i_modr} - r_rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_FR_IDLE) begin
            r_q1   <= i_key;
            r_q2   <= i_key;
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_cnt  <= '0;
        end else if (r_state == T_FR_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            r_q1  <= r_q1 << 1;
            r_q2  <= r_q2 << 1;
            if (w_t1 >= {1'b0, i_size}) r_rem1 <= 7'(w_t1 - {1'b0, i_size});
            else                        r_rem1 <= w_t1[6:0];
            if (w_t2 >= {2'b0, i_modr}) r_rem2 <= 17'(w_t2 - {2'b0, i_modr});
            else                        r_rem2 <= w_t2[16:0];
        end
    end

`ifndef SYNTHESIS
    a_home_lt_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_home < i_size)) else $error("home out of range");
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_step != 17'd0)) else $error("zero step");
    a_push_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !o_push) else $error("double push");
`endif
endmodule

// ----- design/dhi_back.sv -----
module dhi_back import dhi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_qvalid,
    output logic        o_pop,
    input  logic [6:0]  i_home,
    input  logic [16:0] i_step,
    input  logic [6:0]  i_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_slot,
    output logic        o_stored,
    output logic [5:0]  o_probe_collisions,
    output logic [15:0] o_total_collisions
);
    t_back_state r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [6:0]  r_pos, r_stepm, r_hits;
    logic [16:0] r_sred;
    logic [4:0]  r_rcnt;
    logic        r_hit_free;
    logic [15:0] r_total;
    logic [7:0]  w_next;
    logic [7:0]  w_t;
    logic        w_free;

    assign w_free = !r_valid[r_pos[IDX_W-1:0]];
    assign w_next = {1'b0, r_pos} + {1'b0, r_stepm};
    assign w_t    = {r_stepm, r_sred[16]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_BK_IDLE:  if (i_qvalid) n_state = T_BK_READ;
            T_BK_READ:  if (r_rcnt == 5'd16) n_state = T_BK_CHECK;
            T_BK_CHECK: if (w_free || (r_hits + 7'd1 == i_size)) n_state = T_BK_OUT;
            T_BK_OUT:   if (!i_stall) n_state = T_BK_IDLE;
            default:    n_state = T_BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == T_BK_IDLE) && i_qvalid;
        o_valid = (r_state == T_BK_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_BK_IDLE;
            r_valid <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == T_BK_CHECK) begin
                if (w_free) begin
                    r_valid[r_pos[IDX_W-1:0]] <= 1'b1;
                end
                if (w_free || (r_hits + 7'd1 == i_size)) begin
                    if ({1'b0, r_total} + {10'b0, r_hits} + {16'b0, !w_free} > 17'd65535)
                        r_total <= 16'hFFFF;
                    else
                        r_total <= 16'(r_total + r_hits + {15'b0, !w_free});
                end
            end
        end
    end

    // step reduced mod size, one step bit per cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            T_BK_IDLE: begin
                r_pos   <= i_home;
                r_sred  <= i_step;
                r_hits  <= '0;
                r_stepm <= '0;
                r_rcnt  <= '0;
            end
            T_BK_READ: begin
                r_rcnt <= r_rcnt + 5'd1;
                r_sred <= r_sred << 1;
                if (w_t >= {1'b0, i_size}) r_stepm <= 7'(w_t - {1'b0, i_size});
                else                       r_stepm <= w_t[6:0];
            end
            T_BK_CHECK: begin
                r_hit_free <= w_free;
                if (!w_free) begin
                    r_hits <= r_hits + 7'd1;
                    r_pos  <= (w_next >= {1'b0, i_size}) ? 7'(w_next - {1'b0, i_size})
                                                         : w_next[6:0];
                end
            end
            default: ;
        endcase
    end

    assign o_stored           = r_hit_free;
    assign o_slot             = r_hit_free ? r_pos[4:0] : 5'd0;
    assign o_probe_collisions = r_hits[5:0];
    assign o_total_collisions = r_total;

`ifndef SYNTHESIS
    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_hits} <= {1'b0, i_size})) else $error("hits overflow");
    a_fail_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_stored) |-> (r_hits == i_size)) else $error("early fail");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_BK_CHECK) |-> (r_pos < i_size)) else $error("probe range");
`endif
endmodule

// ----- design/double_hash_insert.sv -----
// Flow from input transfer to result valid: the front derives the key remainders bit-serially,
// the result passes through the queue, the back reduces the step mod size bit-serially,
// then probes p slots, p = probes (1 to table_size). The front can take a new key once
// its last result has entered the queue: front and back overlap through a one-entry queue.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the total and
// restores table_size 27 and second_modulus 23.
module double_hash_insert import dhi_pkg::*; #(
    parameter int KEY_WIDTH   = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KEY_WIDTH-1:0] i_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [4:0]           o_slot,
    output logic                 o_stored,
    output logic [5:0]           o_probe_collisions,
    output logic [15:0]          o_total_collisions,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [5:0]  r_table_size;
    logic [15:0] r_second_mod;
    logic [6:0]  w_size;
    logic [15:0] w_modr;
    logic        w_push, w_pop, r_qv;
    logic [6:0]  w_home, r_qhome;
    logic [16:0] w_step, r_qstep;

    assign pready = 1'b1;
    assign w_size = (r_table_size == 6'd0) ? 7'd1 :
                    ({1'b0, r_table_size} > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) :
                    {1'b0, r_table_size};
    assign w_modr = (r_second_mod == 16'd0) ? 16'd1 : r_second_mod;

    always_comb begin
        unique case (paddr[2])
            1'b0:    prdata = {26'b0, r_table_size};
            default: prdata = {16'b0, r_second_mod};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 6'd27;
            r_second_mod <= 16'd23;
            r_qv         <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'(4 * CFG_TABLE_SIZE)) r_table_size <= pwdata[5:0];
                if (paddr == 3'(4 * CFG_SECOND_MOD)) r_second_mod <= pwdata[15:0];
            end
            if (w_push)     r_qv <= 1'b1;
            else if (w_pop) r_qv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qhome <= w_home;
            r_qstep <= w_step;
        end
    end

    dhi_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_key,
        .i_size(w_size), .i_modr(w_modr), .o_push(w_push), .i_full(r_qv),
        .o_home(w_home), .o_step(w_step)
    );

    dhi_back u_back (
        .i_clk, .i_rst_n, .i_qvalid(r_qv), .o_pop(w_pop),
        .i_home(r_qhome), .i_step(r_qstep), .i_size(w_size),
        .o_valid, .i_stall, .o_slot, .o_stored, .o_probe_collisions,
        .o_total_collisions
    );
endmodule

// ----- bench/dhi_checker.sv -----
module dhi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [30:0] i_key,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [4:0]  o_slot,
    input  logic        o_stored,
    input  logic [5:0]  o_probe_collisions,
    input  logic [15:0] o_total_collisions,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dhi_pkg::*;

    typedef struct packed {
        logic [4:0]  slot;
        logic        stored;
        logic [5:0]  hits;
        logic [15:0] total;
    } t_insert;

    t_insert     expected_q[$];
    logic [31:0] occupied;
    logic [15:0] running_total;
    logic [5:0]  size_reg;
    logic [15:0] modulus_reg;

    function automatic t_insert insert_key(input logic [30:0] key);
        t_insert     r;
        int unsigned m, rr, home, step, pos, i;
        r = '0;
        m = (size_reg == 0) ? 1 : ((size_reg > 32) ? 32 : size_reg);
        rr = (modulus_reg == 0) ? 1 : modulus_reg;
        home = key % m;
        step = rr - (key % rr);
        for (i = 0; i < m; i++) begin
            pos = (home + i * step) % m;
            if (!occupied[pos]) begin
                occupied[pos] = 1'b1;
                r.slot = pos[4:0];
                r.stored = 1'b1;
                break;
            end
            r.hits++;
        end
        if (running_total + r.hits > 65535) running_total = 16'hFFFF;
        else running_total = 16'(running_total + r.hits);
        r.total = running_total;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge i_clk) begin
        t_insert e;
        if (!i_rst_n) begin
            occupied = '0;
            running_total = '0;
            size_reg = 6'd27;
            modulus_reg = 16'd23;
            expected_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'(4 * CFG_TABLE_SIZE)) size_reg = pwdata[5:0];
                else if (paddr == 3'(4 * CFG_SECOND_MOD)) modulus_reg = pwdata[15:0];
            end
            if (i_valid && !o_stall) expected_q = {expected_q, insert_key(i_key)};
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_slot !== e.slot) begin
                        $error("slot exp %0d got %0d", e.slot, o_slot); errors++;
                    end
                    if (o_stored !== e.stored) begin
                        $error("stored exp %0d got %0d", e.stored, o_stored); errors++;
                    end
                    if (o_probe_collisions !== e.hits) begin
                        $error("probe_collisions exp %0d got %0d", e.hits,
                               o_probe_collisions); errors++;
                    end
                    if (o_total_collisions !== e.total) begin
                        $error("total_collisions exp %0d got %0d", e.total,
                               o_total_collisions); errors++;
                    end
                end
            end
        end
    end
endmodule

// ----- bench/tb_double_hash_insert.sv -----
module tb_double_hash_insert;
    timeunit 1ns;
    timeprecision 1ps;
    import dhi_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [30:0] i_key = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [4:0]  o_slot;
    logic        o_stored;
    logic [5:0]  o_probe_collisions;
    logic [15:0] o_total_collisions;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          stall_mode = 0;

    always #5 i_clk = ~i_clk;

    double_hash_insert DUT (.*);
    dhi_checker u_checker (.*);

    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic send_key(input logic [30:0] key);
        i_valid <= 1'b1;
        i_key <= key;
        do @(posedge i_clk); while (o_stall);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(4 * idx); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [30:0] k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_key('0);
        send_key(31'h7FFF_FFFF);
        send_key(31'h5555_5555);
        send_key(31'h2AAA_AAAA);
        send_key(31'd27);
        send_key(31'd27);
        drain();
        write_reg(CFG_TABLE_SIZE, 32'd1);
        write_reg(CFG_SECOND_MOD, 32'd0);
        send_key(31'd5); send_key(31'd9); send_key(31'h7FFF_FFFF);
        drain();
        write_reg(CFG_TABLE_SIZE, 32'd0);
        send_key(31'd3);
        drain();
        write_reg(CFG_TABLE_SIZE, 32'd63);
        write_reg(CFG_SECOND_MOD, 32'hFFFF);
        for (int i = 0; i < 12; i++) send_key(31'(i * 7));
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_TABLE_SIZE, $urandom_range(0, 40));
            case (ph)
                0: write_reg(CFG_SECOND_MOD, 32'd1);
                1: write_reg(CFG_SECOND_MOD, 32'd65535);
                2: write_reg(CFG_SECOND_MOD, 32'd0);
                default: write_reg(CFG_SECOND_MOD, $urandom_range(1, 40));
            endcase
            stall_mode <= ph % 3;
            for (int n = 0; n < 100; n++) begin
                case ($urandom_range(0, 2))
                    0: k = 31'($urandom());
                    1: k = 31'($urandom_range(0, 100));
                    default: k = {1'($urandom_range(0, 1)), 30'($urandom_range(0, 64))};
                endcase
                send_key(k);
            end
            drain();
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
